[sv/tes_pkg.sv]
package tes_pkg;

   localparam int FIELD_W    = 24;
   localparam int NUM_ROLES  = 10;
   localparam int NUM_CMP    = 6;
   localparam int MAX_PIECES = 8;

   typedef enum logic [3:0] {
      SPLIT_NONE,
      SPLIT_ONE,
      SPLIT_TWO_ADJ,
      SPLIT_TWO_OPP,
      SPLIT_THREE_CORNER,
      SPLIT_THREE_FACE,
      SPLIT_THREE_PATH,
      SPLIT_FOUR_STAR,
      SPLIT_FOUR_RING,
      SPLIT_FIVE,
      SPLIT_SIX
   } split_type;

   typedef logic [1:0] vtx_type;
   // role: 0..3 local corners ln1..ln4, 4..9 midpoints n5..n10
   typedef logic [3:0] role_type;
   // slot: 0..3 vertex ids, 4..9 midpoint ids by edge, 10 reads zero
   typedef logic [3:0] slot_type;

   localparam slot_type SLOT_ZERO = 4'd10;

   localparam role_type L1  = 4'd0;
   localparam role_type L2  = 4'd1;
   localparam role_type L3  = 4'd2;
   localparam role_type L4  = 4'd3;
   localparam role_type N5  = 4'd4;
   localparam role_type N6  = 4'd5;
   localparam role_type N7  = 4'd6;
   localparam role_type N8  = 4'd7;
   localparam role_type N9  = 4'd8;
   localparam role_type N10 = 4'd9;

   typedef role_type [3:0] quad_type;

   typedef struct packed {
      quad_type [MAX_PIECES-1:0] pc;
      logic [3:0]                n;
   } plan_type;

   typedef struct packed {
      split_type        kind;
      vtx_type   [3:0]  ln;
   } shape_type;

   localparam vtx_type EDGE_A [6] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1};
   localparam vtx_type EDGE_B [6] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
   localparam vtx_type OPP_A  [6] = '{2'd2, 2'd0, 2'd3, 2'd0, 2'd2, 2'd2};
   localparam vtx_type OPP_B  [6] = '{2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd0};
   localparam logic [2:0] VERT_EDGE [4][3] = '{
      '{3'd0, 3'd2, 3'd4}, '{3'd0, 3'd1, 3'd5},
      '{3'd1, 3'd2, 3'd3}, '{3'd3, 3'd4, 3'd5}};

   // edge index of a vertex pair, 6 when the pair is no edge
   function automatic logic [2:0] edge_of(input vtx_type a, input vtx_type b);
      logic [2:0] r;
      r = 3'd6;
      for (int e = 5; e >= 0; e--)
         if ((EDGE_A[e] == a && EDGE_B[e] == b) || (EDGE_A[e] == b && EDGE_B[e] == a))
            r = 3'(e);
      return r;
   endfunction

   function automatic logic [3:0] opp_of(input vtx_type a, input vtx_type b);
      logic [2:0] e;
      e = edge_of(a, b);
      return (e < 3'd6) ? {OPP_A[e], OPP_B[e]} : 4'd0;
   endfunction

   // pick the split pattern and the local vertex numbering from the marks
   function automatic shape_type decode(input logic [5:0] mk);
      shape_type  sh;
      logic [1:0] cnt [4];
      logic [2:0] nm;
      logic [1:0] mm;
      logic [2:0] fm, fu, e, jj;
      vtx_type    c0, c1, c2, c3, oth;
      logic       has0, has3, first;
      logic [3:0] o;
      nm = '0; mm = '0; fm = 3'd5; fu = 3'd5;
      c0 = '0; c1 = '0; c2 = '0; c3 = '0; has0 = 1'b0; has3 = 1'b0;
      for (int k = 0; k < 6; k++) nm = nm + 3'(mk[k]);
      for (int k = 5; k >= 0; k--) begin
         if (mk[k]) fm = 3'(k);
         if (!mk[k]) fu = 3'(k);
      end
      for (int v = 0; v < 4; v++) begin
         cnt[v] = '0;
         for (int j = 0; j < 3; j++) cnt[v] = cnt[v] + 2'(mk[VERT_EDGE[v][j]]);
         if (cnt[v] > mm) mm = cnt[v];
         if (cnt[v] == 2'd0) begin c0 = 2'(v); has0 = 1'b1; end
         if (cnt[v] == 2'd1) c1 = 2'(v);
         if (cnt[v] == 2'd2) c2 = 2'(v);
         if (cnt[v] == 2'd3) begin c3 = 2'(v); has3 = 1'b1; end
      end
      sh.kind = SPLIT_NONE;
      sh.ln   = '0;
      case (nm)
         3'd0: begin
            sh.kind = SPLIT_NONE;
            sh.ln   = {2'd3, 2'd2, 2'd1, 2'd0};
         end
         3'd1: begin
            sh.kind = SPLIT_ONE;
            sh.ln   = {OPP_B[fm], OPP_A[fm], EDGE_B[fm], EDGE_A[fm]};
         end
         3'd2: begin
            if (mm == 2'd2) begin
               sh.kind  = SPLIT_TWO_ADJ;
               o        = opp_of(c0, c2);
               sh.ln    = {c2, c0, o[1:0], o[3:2]};
            end else begin
               sh.kind = SPLIT_TWO_OPP;
               sh.ln   = {OPP_B[fm], OPP_A[fm], EDGE_B[fm], EDGE_A[fm]};
            end
         end
         3'd3: begin
            if (has3) begin
               sh.kind = SPLIT_THREE_CORNER;
               o       = opp_of(vtx_type'(c3 + 2'd1), c3);
               sh.ln   = {c3, o[1:0], o[3:2], vtx_type'(c3 + 2'd1)};
            end else if (has0) begin
               sh.kind = SPLIT_THREE_FACE;
               o       = opp_of(c0, vtx_type'(c0 + 2'd1));
               sh.ln   = {vtx_type'(c0 + 2'd1), c0, o[1:0], o[3:2]};
            end else begin
               sh.kind = SPLIT_THREE_PATH;
               first   = 1'b1;
               for (int v = 0; v < 4; v++) begin
                  if (cnt[v] == 2'd1) begin
                     jj = 3'd2;
                     for (int j = 2; j >= 0; j--)
                        if (mk[VERT_EDGE[v][j]]) jj = 3'(j);
                     e   = VERT_EDGE[v][jj[1:0]];
                     oth = (EDGE_A[e] == 2'(v)) ? EDGE_B[e] : EDGE_A[e];
                     if (first) begin
                        sh.ln[0] = 2'(v); sh.ln[3] = oth; first = 1'b0;
                     end else begin
                        sh.ln[1] = 2'(v); sh.ln[2] = oth;
                     end
                  end
               end
            end
         end
         3'd4: begin
            if (mm == 2'd3) begin
               sh.kind = SPLIT_FOUR_STAR;
               o       = opp_of(c1, c3);
               sh.ln   = {c3, c1, o[1:0], o[3:2]};
            end else begin
               sh.kind = SPLIT_FOUR_RING;
               sh.ln   = {OPP_B[fu], OPP_A[fu], EDGE_B[fu], EDGE_A[fu]};
            end
         end
         3'd5: begin
            sh.kind = SPLIT_FIVE;
            sh.ln   = {OPP_B[fu], OPP_A[fu], EDGE_B[fu], EDGE_A[fu]};
         end
         default: begin
            sh.kind = SPLIT_SIX;
            sh.ln   = {2'd3, 2'd2, 2'd1, 2'd0};
         end
      endcase
      return sh;
   endfunction

   function automatic logic [3:0] pair(input role_type a, input role_type b);
      return {a[1:0], b[1:0]};
   endfunction

   // corner pair of each midpoint role n5..n10, as corner roles
   function automatic logic [5:0][3:0] mid_pairs(input split_type k);
      logic [5:0][3:0] p;
      p = '0;
      unique case (k)
         SPLIT_ONE: p[0] = pair(L1, L2);
         SPLIT_TWO_ADJ: begin p[0] = pair(L2, L4); p[1] = pair(L1, L4); end
         SPLIT_TWO_OPP: begin p[0] = pair(L1, L2); p[1] = pair(L3, L4); end
         SPLIT_THREE_CORNER: begin
            p[0] = pair(L3, L4); p[1] = pair(L1, L4); p[2] = pair(L2, L4);
         end
         SPLIT_THREE_FACE: begin
            p[0] = pair(L1, L4); p[1] = pair(L1, L2); p[2] = pair(L2, L4);
         end
         SPLIT_THREE_PATH: begin
            p[0] = pair(L1, L4); p[1] = pair(L2, L3); p[2] = pair(L3, L4);
         end
         SPLIT_FOUR_STAR: begin
            p[0] = pair(L1, L2); p[1] = pair(L2, L4);
            p[2] = pair(L3, L4); p[3] = pair(L1, L4);
         end
         SPLIT_FOUR_RING: begin
            p[0] = pair(L1, L4); p[1] = pair(L1, L3);
            p[2] = pair(L2, L3); p[3] = pair(L2, L4);
         end
         SPLIT_FIVE: begin
            p[0] = pair(L1, L4); p[1] = pair(L1, L3); p[2] = pair(L2, L3);
            p[3] = pair(L3, L4); p[4] = pair(L2, L4);
         end
         SPLIT_SIX: begin
            p[0] = pair(L1, L4); p[1] = pair(L2, L4); p[2] = pair(L3, L4);
            p[3] = pair(L1, L3); p[4] = pair(L1, L2); p[5] = pair(L2, L3);
         end
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic quad_type quad(input role_type a, input role_type b,
                                     input role_type c, input role_type d);
      quad_type q;
      q[0] = a; q[1] = b; q[2] = c; q[3] = d;
      return q;
   endfunction

   // diagonal tests: each entry reads max(q0,q1) > max(q2,q3)
   function automatic quad_type [NUM_CMP-1:0] cmp_roles(input split_type k);
      quad_type [NUM_CMP-1:0] c;
      c = '0;
      unique case (k)
         SPLIT_TWO_ADJ: c[0] = quad(L1, N5, L2, N6);
         SPLIT_THREE_CORNER: begin
            c[0] = quad(L1, N5, N6, L3);
            c[1] = quad(L2, N6, N7, L1);
            c[2] = quad(L2, N5, N7, L3);
         end
         SPLIT_THREE_PATH: begin
            c[0] = quad(N6, L4, N7, L2);
            c[1] = quad(L3, N5, L1, N7);
         end
         SPLIT_FOUR_STAR: begin
            c[0] = quad(L2, N7, L3, N6);
            c[1] = quad(L1, N7, N8, L3);
         end
         SPLIT_FOUR_RING: begin
            c[0] = quad(L4, N6, L3, N5);
            c[1] = quad(N8, L3, N7, L4);
            c[2] = quad(N8, N6, N7, N5);
            c[3] = quad(N5, N7, N8, N6);
            c[4] = quad(L1, N8, L2, N5);
            c[5] = quad(L1, N7, L2, N6);
         end
         SPLIT_FIVE: begin
            c[0] = quad(N6, N9, N7, N5);
            c[1] = quad(N5, N7, N9, N6);
            c[2] = quad(L1, N9, L2, N5);
            c[3] = quad(L1, N7, L2, N6);
         end
         SPLIT_SIX: c[0] = quad(N7, N9, N5, N10);
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic plan_type put(input plan_type p, input role_type a, input role_type b,
                                    input role_type c, input role_type d);
      plan_type r;
      r = p;
      r.pc[p.n[2:0]] = quad(a, b, c, d);
      r.n = p.n + 4'd1;
      return r;
   endfunction

   function automatic plan_type pyr(input plan_type p, input role_type i1, input role_type i2,
                                    input role_type i3, input role_type i4, input role_type i5,
                                    input logic s);
      plan_type r;
      if (s) begin
         r = put(p, i1, i2, i5, i3); r = put(r, i1, i5, i4, i3);
      end else begin
         r = put(p, i1, i2, i5, i4); r = put(r, i2, i3, i5, i4);
      end
      return r;
   endfunction

   function automatic plan_type prism(input plan_type p, input role_type i1, input role_type i2,
                                      input role_type i3, input role_type i4,
                                      input role_type i5, input role_type i6,
                                      input logic s46, input logic s13, input logic s16);
      plan_type r;
      if (s46) begin
         if (s13) begin
            r = put(p, i1, i2, i6, i3); r = put(r, i1, i6, i4, i3); r = put(r, i1, i6, i5, i4);
         end else if (s16) begin
            r = put(p, i1, i2, i6, i4); r = put(r, i1, i6, i5, i4); r = put(r, i2, i6, i4, i3);
         end else begin
            r = put(p, i1, i2, i5, i4); r = put(r, i2, i3, i6, i4); r = put(r, i2, i6, i5, i4);
         end
      end else if (s13) begin
         if (s16) begin
            r = put(p, i1, i2, i6, i3); r = put(r, i1, i3, i5, i4); r = put(r, i1, i6, i5, i3);
         end else begin
            r = put(p, i1, i3, i5, i4); r = put(r, i2, i5, i1, i3); r = put(r, i2, i6, i5, i3);
         end
      end else begin
         r = put(p, i1, i2, i5, i4); r = put(r, i2, i3, i5, i4); r = put(r, i2, i6, i5, i3);
      end
      return r;
   endfunction

   function automatic plan_type octo(input plan_type p, input role_type i1, input role_type i2,
                                     input role_type i3, input role_type i4,
                                     input role_type i5, input role_type i6, input logic s);
      plan_type r;
      if (s) begin
         r = put(p, i1, i3, i4, i5); r = put(r, i1, i3, i5, i6);
         r = put(r, i3, i4, i5, i2); r = put(r, i3, i5, i6, i2);
      end else begin
         r = put(p, i1, i4, i6, i3); r = put(r, i1, i6, i4, i5);
         r = put(r, i2, i4, i6, i5); r = put(r, i2, i6, i4, i3);
      end
      return r;
   endfunction

   // list of sub-tetrahedra as roles, from pattern and diagonal tests
   function automatic plan_type make_plan(input split_type k, input logic [NUM_CMP-1:0] g);
      plan_type p;
      p = '0;
      unique case (k)
         SPLIT_NONE: p = put(p, L1, L2, L3, L4);
         SPLIT_ONE: begin
            p = put(p, L3, L4, N5, L2); p = put(p, L4, L3, N5, L1);
         end
         SPLIT_TWO_ADJ: begin
            p = pyr(p, L1, L2, N5, N6, L3, g[0]); p = put(p, N6, N5, L3, L4);
         end
         SPLIT_TWO_OPP: begin
            p = put(p, L2, L3, N5, N6); p = put(p, L2, N6, N5, L4);
            p = put(p, L1, N5, N6, L4); p = put(p, L1, N5, L3, N6);
         end
         SPLIT_THREE_CORNER: begin
            p = put(p, L4, N7, N6, N5);
            p = prism(p, L2, N7, N6, L1, L3, N5, g[0], g[1], g[2]);
         end
         SPLIT_THREE_FACE: begin
            p = put(p, L1, N6, L3, N5); p = put(p, L2, L3, N6, N7);
            p = put(p, N6, L3, N5, N7); p = put(p, N5, N7, L3, L4);
         end
         SPLIT_THREE_PATH: begin
            p = pyr(p, N6, N7, L4, L2, N5, g[0]);
            p = pyr(p, L3, L1, N5, N7, N6, g[1]);
            p = put(p, L1, L2, N6, N5);
         end
         SPLIT_FOUR_STAR: begin
            p = put(p, N8, N6, N7, L4); p = put(p, N7, N8, N5, N6);
            p = pyr(p, L2, L3, N7, N6, N5, g[0]);
            p = pyr(p, L1, N8, N7, L3, N5, g[1]);
         end
         SPLIT_FOUR_RING: begin
            p = prism(p, N8, N7, L3, L4, N5, N6, g[0], g[1], g[2]);
            p = prism(p, L1, L2, N8, N5, N6, N7, g[3], g[4], g[5]);
         end
         SPLIT_FIVE: begin
            p = put(p, N9, N8, N5, L4); p = put(p, L3, N6, N7, N8);
            p = pyr(p, N6, N7, N9, N5, N8, g[0]);
            p = prism(p, L1, L2, N9, N5, N6, N7, g[1], g[2], g[3]);
         end
         SPLIT_SIX: begin
            p = put(p, L1, N9, N8, N5); p = put(p, L2, N10, N9, N6);
            p = put(p, L3, N8, N10, N7); p = put(p, N5, N6, N7, L4);
            p = octo(p, N8, N6, N7, N5, N9, N10, g[0]);
         end
         default: p = put(p, L1, L2, L3, L4);
      endcase
      return p;
   endfunction

endpackage

[sv/tetrahedron_edge_split_top.sv]
// Tetrahedron edge splitter: one tetrahedron word in, one to eight
// sub-tetrahedron words out, the last flagged by rsp_last_piece. Four register
// stages (input capture, pattern decode, diagonal maxima, diagonal compare)
// feed a piece sequencer, so a new tetrahedron can enter every cycle unless
// the stages are backed up behind a busy sequencer. The result port moves one
// piece per cycle while rsp_stall is low; the sequencer takes the next
// tetrahedron as the last piece of the one before leaves. An unmarked tetrahedron
// passes through whole, one with all edges marked gives MAX_PIECES. Node ids are
// cut to NODE_ID_WIDTH (at most FIELD_W) bits. Stalls on either side lose nothing.
module tetrahedron_edge_split_top
   import tes_pkg::*;
#(
   parameter int NODE_ID_WIDTH = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_vertex_0,
   input  logic [FIELD_W-1:0] req_vertex_1,
   input  logic [FIELD_W-1:0] req_vertex_2,
   input  logic [FIELD_W-1:0] req_vertex_3,
   input  logic [FIELD_W-1:0] req_mid_01,
   input  logic [FIELD_W-1:0] req_mid_12,
   input  logic [FIELD_W-1:0] req_mid_02,
   input  logic [FIELD_W-1:0] req_mid_23,
   input  logic [FIELD_W-1:0] req_mid_03,
   input  logic [FIELD_W-1:0] req_mid_13,
   input  logic [FIELD_W-1:0] req_parent_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_sub_node_0,
   output logic [FIELD_W-1:0] rsp_sub_node_1,
   output logic [FIELD_W-1:0] rsp_sub_node_2,
   output logic [FIELD_W-1:0] rsp_sub_node_3,
   output logic [FIELD_W-1:0] rsp_parent_out,
   output logic               rsp_last_piece
);

   localparam int IdW = (NODE_ID_WIDTH < FIELD_W) ? NODE_ID_WIDTH : FIELD_W;

   typedef logic [IdW-1:0] id_type;
   // ids by slot: 0..3 vertices, 4..9 midpoints in edge order
   typedef id_type [NUM_ROLES-1:0] vals_type;
   typedef slot_type [NUM_ROLES-1:0] slots_type;
   typedef id_type [NUM_CMP-1:0] maxes_type;
   typedef slot_type [3:0] pslots_type;

   function automatic id_type slot_val(input vals_type v, input slot_type s);
      return (s < SLOT_ZERO) ? v[s] : '0;
   endfunction

   // pipeline flow: a stage loads when empty or when its word moves on
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, ser_vld_ff;
   logic s1_free, s2_free, s3_free, s4_free, ser_take, ser_last;

   assign ser_take = s4_vld_ff && (!ser_vld_ff || (ser_last && !rsp_stall));
   assign s4_free  = !s4_vld_ff || ser_take;
   assign s3_free  = !s3_vld_ff || s4_free;
   assign s2_free  = !s2_vld_ff || s3_free;
   assign s1_free  = !s1_vld_ff || s2_free;
   assign req_stall = !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (s1_free) s1_vld_ff <= req_valid;
         if (s2_free) s2_vld_ff <= s1_vld_ff;
         if (s3_free) s3_vld_ff <= s2_vld_ff;
         if (s4_free) s4_vld_ff <= s3_vld_ff;
      end
   end

   // stage 1: capture the word, ids cut to the configured width
   vals_type           s1_val_ff, s1_val_in;
   logic [FIELD_W-1:0] s1_par_ff;

   always_comb begin
      s1_val_in[0] = IdW'(req_vertex_0);
      s1_val_in[1] = IdW'(req_vertex_1);
      s1_val_in[2] = IdW'(req_vertex_2);
      s1_val_in[3] = IdW'(req_vertex_3);
      s1_val_in[4] = IdW'(req_mid_01);
      s1_val_in[5] = IdW'(req_mid_12);
      s1_val_in[6] = IdW'(req_mid_02);
      s1_val_in[7] = IdW'(req_mid_23);
      s1_val_in[8] = IdW'(req_mid_03);
      s1_val_in[9] = IdW'(req_mid_13);
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_val_ff <= s1_val_in;
         s1_par_ff <= req_parent_in;
      end
   end

   // stage 2: decode the mark pattern, map every role onto an id slot
   logic [5:0]         s2_mark;
   shape_type          s2_shape;
   logic [5:0][3:0]    s2_pairs;
   logic [2:0]         s2_edge [6];
   slots_type          s2_slot_ff, s2_slot_in;
   split_type          s2_kind_ff;
   vals_type           s2_val_ff;
   logic [FIELD_W-1:0] s2_par_ff;

   always_comb begin
      for (int e = 0; e < 6; e++) s2_mark[e] = (s1_val_ff[4 + e] != '0);
      s2_shape = decode(s2_mark);
      s2_pairs = mid_pairs(s2_shape.kind);
      for (int r = 0; r < 4; r++) s2_slot_in[r] = {2'b00, s2_shape.ln[r]};
      for (int m = 0; m < 6; m++) begin
         s2_edge[m] = edge_of(s2_shape.ln[s2_pairs[m][3:2]], s2_shape.ln[s2_pairs[m][1:0]]);
         s2_slot_in[4 + m] = (s2_edge[m] < 3'd6) ? slot_type'(4'd4 + {1'b0, s2_edge[m]})
                                                 : SLOT_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_slot_ff <= s2_slot_in;
         s2_kind_ff <= s2_shape.kind;
         s2_val_ff  <= s1_val_ff;
         s2_par_ff  <= s1_par_ff;
      end
   end

   // stage 3: maxima on both sides of every diagonal test
   quad_type [NUM_CMP-1:0] s3_ops;
   id_type                 s3_op [NUM_CMP][4];
   maxes_type              s3_max_a_ff, s3_max_a_in, s3_max_b_ff, s3_max_b_in;
   slots_type              s3_slot_ff;
   split_type              s3_kind_ff;
   vals_type               s3_val_ff;
   logic [FIELD_W-1:0]     s3_par_ff;

   always_comb begin
      s3_ops = cmp_roles(s2_kind_ff);
      for (int k = 0; k < NUM_CMP; k++) begin
         for (int j = 0; j < 4; j++)
            s3_op[k][j] = slot_val(s2_val_ff, s2_slot_ff[s3_ops[k][j]]);
         s3_max_a_in[k] = (s3_op[k][0] > s3_op[k][1]) ? s3_op[k][0] : s3_op[k][1];
         s3_max_b_in[k] = (s3_op[k][2] > s3_op[k][3]) ? s3_op[k][2] : s3_op[k][3];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_max_a_ff <= s3_max_a_in;
         s3_max_b_ff <= s3_max_b_in;
         s3_slot_ff  <= s2_slot_ff;
         s3_kind_ff  <= s2_kind_ff;
         s3_val_ff   <= s2_val_ff;
         s3_par_ff   <= s2_par_ff;
      end
   end

   // stage 4: settle the diagonals; strict compare, so ties take the second cut
   logic [NUM_CMP-1:0] s4_gt_ff, s4_gt_in;
   slots_type          s4_slot_ff;
   split_type          s4_kind_ff;
   vals_type           s4_val_ff;
   logic [FIELD_W-1:0] s4_par_ff;

   always_comb begin
      for (int k = 0; k < NUM_CMP; k++) s4_gt_in[k] = s3_max_a_ff[k] > s3_max_b_ff[k];
   end

   always_ff @(posedge clock) begin
      if (s4_free) begin
         s4_gt_ff   <= s4_gt_in;
         s4_slot_ff <= s3_slot_ff;
         s4_kind_ff <= s3_kind_ff;
         s4_val_ff  <= s3_val_ff;
         s4_par_ff  <= s3_par_ff;
      end
   end

   // piece sequencer: build the piece list as slots, then hand out one a cycle unless stalled
   plan_type                      ser_plan;
   pslots_type [MAX_PIECES-1:0]   ser_pc_ff, ser_pc_in;
   logic [3:0]                    ser_n_ff;
   logic [2:0]                    ser_k_ff;
   vals_type                      ser_val_ff;
   logic [FIELD_W-1:0]            ser_par_ff;
   pslots_type                    ser_cur;

   always_comb begin
      ser_plan = make_plan(s4_kind_ff, s4_gt_ff);
      for (int p = 0; p < MAX_PIECES; p++)
         for (int j = 0; j < 4; j++)
            ser_pc_in[p][j] = s4_slot_ff[ser_plan.pc[p][j]];
   end

   assign ser_last = ({1'b0, ser_k_ff} == (ser_n_ff - 4'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_k_ff   <= '0;
      end else if (ser_take) begin
         ser_vld_ff <= 1'b1;
         ser_k_ff   <= '0;
      end else if (ser_vld_ff && !rsp_stall) begin
         // drop the word after its last piece, else advance
         if (ser_last) ser_vld_ff <= 1'b0;
         else ser_k_ff <= ser_k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         ser_pc_ff  <= ser_pc_in;
         ser_n_ff   <= ser_plan.n;
         ser_val_ff <= s4_val_ff;
         ser_par_ff <= s4_par_ff;
      end
   end

   assign ser_cur        = ser_pc_ff[ser_k_ff];
   assign rsp_valid      = ser_vld_ff;
   assign rsp_sub_node_0 = FIELD_W'(slot_val(ser_val_ff, ser_cur[0]));
   assign rsp_sub_node_1 = FIELD_W'(slot_val(ser_val_ff, ser_cur[1]));
   assign rsp_sub_node_2 = FIELD_W'(slot_val(ser_val_ff, ser_cur[2]));
   assign rsp_sub_node_3 = FIELD_W'(slot_val(ser_val_ff, ser_cur[3]));
   assign rsp_parent_out = ser_par_ff;
   assign rsp_last_piece = ser_last;

`ifndef SYNTH
   a_empty_front_takes: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> !req_stall)
      else $error("input stalled with an empty capture stage");

   a_piece_holds: assert property (@(posedge clock) disable iff (reset)
      ser_vld_ff && rsp_stall |=> ser_vld_ff && $stable(ser_k_ff))
      else $error("piece index moved while the result port was stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ser_vld_ff |-> ser_n_ff != 4'd0 && ser_n_ff <= 4'd8)
      else $error("piece count out of range");

   a_stage4_holds: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff && !s4_free |=> s4_vld_ff && $stable(s4_kind_ff))
      else $error("compare stage word lost under stall");
`endif

endmodule
